// File: src/ipms_pkg.sv
// Package for the incremental PID motor speed block: widths, register indexes,
// controller states, mux selects and the command and configuration structs.
// No dependencies.
package ipms_pkg;

  // Field and datapath widths
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = COEF_W + ERR_W;
  localparam int DRIVE_W  = 48;
  localparam int ACC_W    = PROD_W + 2;
  localparam int RATED_W  = 23;
  localparam int DUTY_W   = 7;
  localparam int DUTY_FULL = 100;
  localparam int NUM_W    = RATED_W + DUTY_W;
  localparam int DIV_STEPS = DUTY_W;
  localparam int SHIFT_W  = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_A        = 2'd0,
    REG_COEF_B        = 2'd1,
    REG_COEF_C        = 2'd2,
    REG_RATED_VOLTAGE = 2'd3
  } reg_idx_t;

  localparam logic signed [COEF_W-1:0] COEF_A_RST = 32'sd13107;
  localparam logic signed [COEF_W-1:0] COEF_B_RST = -32'sd13107;
  localparam logic signed [COEF_W-1:0] COEF_C_RST = 32'sd0;
  localparam logic [RATED_W-1:0]       RATED_RST  = 23'd786432;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic [RATED_W-1:0]       rated_voltage;
  } cfg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_ACC_C,
    ST_CLAMP,
    ST_SCALE,
    ST_DIV,
    ST_WRITE
  } state_t;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MS_A,
    MS_B,
    MS_C
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               load_in;
    logic               mul_en;
    mul_sel_t           mul_sel;
    logic               acc_en;
    logic               update;
    logic               scale;
    logic               div_step;
    logic [SHIFT_W-1:0] div_shift;
    logic               out_load;
  } cmd_t;

endpackage

// File: src/ipms_in_if.sv
// Input channel interface: valid/ready plus target and measured speed.
// Depends on ipms_pkg.
interface ipms_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ipms_pkg::SPEED_W-1:0] target_speed;
  logic signed [ipms_pkg::SPEED_W-1:0] measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

// File: src/ipms_out_if.sv
// Result channel interface: valid/ready plus duty and direction.
// Depends on ipms_pkg.
interface ipms_out_if;
  logic                         valid;
  logic                         ready;
  logic [ipms_pkg::DUTY_W-1:0]  duty_percent;
  logic                         direction;

  modport source (output valid, output duty_percent, output direction, input ready);
  modport sink   (input valid, input duty_percent, input direction, output ready);
endinterface

// File: src/ipms_cfg_if.sv
// Configuration write channel interface: valid/ready, register index, data.
// Depends on ipms_pkg.
interface ipms_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ipms_pkg::CFG_ADDR_W-1:0]  addr;
  logic [ipms_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: src/ipms_cfg.sv
// Configuration register file: PID coefficients and rated voltage.
// Depends on ipms_pkg and ipms_cfg_if.
module ipms_cfg (
  input  logic           clk,
  input  logic           rst_n,
  ipms_cfg_if.sink       cfg_ch,
  output ipms_pkg::cfg_t cfg
);

  ipms_pkg::cfg_t cfg_r;
  ipms_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (ipms_pkg::reg_idx_t'(cfg_ch.addr))
        ipms_pkg::REG_COEF_A:        cfg_nxt.coef_a = cfg_ch.data;
        ipms_pkg::REG_COEF_B:        cfg_nxt.coef_b = cfg_ch.data;
        ipms_pkg::REG_COEF_C:        cfg_nxt.coef_c = cfg_ch.data;
        ipms_pkg::REG_RATED_VOLTAGE: cfg_nxt.rated_voltage = cfg_ch.data[ipms_pkg::RATED_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_a        <= ipms_pkg::COEF_A_RST;
      cfg_r.coef_b        <= ipms_pkg::COEF_B_RST;
      cfg_r.coef_c        <= ipms_pkg::COEF_C_RST;
      cfg_r.rated_voltage <= ipms_pkg::RATED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/ipms_ctrl.sv
// Controller state machine: sequences multiply-accumulate, clamp, scale,
// duty division and result hand-off. Depends on ipms_pkg.
module ipms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ipms_pkg::cmd_t cmd
);

  ipms_pkg::state_t                 state_r, state_nxt;
  logic [ipms_pkg::SHIFT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             slot_free;

  // result slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      ipms_pkg::ST_IDLE:  if (in_valid) state_nxt = ipms_pkg::ST_MUL_A;
      ipms_pkg::ST_MUL_A: state_nxt = ipms_pkg::ST_MUL_B;
      ipms_pkg::ST_MUL_B: state_nxt = ipms_pkg::ST_MUL_C;
      ipms_pkg::ST_MUL_C: state_nxt = ipms_pkg::ST_ACC_C;
      ipms_pkg::ST_ACC_C: state_nxt = ipms_pkg::ST_CLAMP;
      ipms_pkg::ST_CLAMP: state_nxt = ipms_pkg::ST_SCALE;
      ipms_pkg::ST_SCALE: begin
        state_nxt   = ipms_pkg::ST_DIV;
        div_cnt_nxt = ipms_pkg::SHIFT_W'(ipms_pkg::DIV_STEPS - 1);
      end
      ipms_pkg::ST_DIV: begin
        if (div_cnt_r == '0) state_nxt = ipms_pkg::ST_WRITE;
        else div_cnt_nxt = div_cnt_r - 1'b1;
      end
      ipms_pkg::ST_WRITE: if (slot_free) state_nxt = ipms_pkg::ST_IDLE;
      default:            state_nxt = ipms_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = ipms_pkg::MS_A;
    cmd.div_shift = div_cnt_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ipms_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ipms_pkg::ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ipms_pkg::MS_A;
      end
      ipms_pkg::ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ipms_pkg::MS_B;
        cmd.acc_en  = 1'b1;
      end
      ipms_pkg::ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ipms_pkg::MS_C;
        cmd.acc_en  = 1'b1;
      end
      ipms_pkg::ST_ACC_C: cmd.acc_en   = 1'b1;
      ipms_pkg::ST_CLAMP: cmd.update   = 1'b1;
      ipms_pkg::ST_SCALE: cmd.scale    = 1'b1;
      ipms_pkg::ST_DIV:   cmd.div_step = 1'b1;
      ipms_pkg::ST_WRITE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipms_pkg::ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/ipms_dp.sv
// Datapath: error history, shared 32x17 multiplier with accumulator, drive
// clamp, duty scaling and restoring divider, result register. Depends on ipms_pkg.
module ipms_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ipms_pkg::cmd_t                      cmd,
  input  ipms_pkg::cfg_t                      cfg,
  input  logic signed [ipms_pkg::SPEED_W-1:0] target_speed,
  input  logic signed [ipms_pkg::SPEED_W-1:0] measured_speed,
  output logic [ipms_pkg::DUTY_W-1:0]         duty_percent,
  output logic                                direction
);

  localparam int ACC_EXT = ipms_pkg::ACC_W - ipms_pkg::PROD_W;
  localparam int HI_W    = ipms_pkg::ACC_W - ipms_pkg::DRIVE_W + 1;

  // architectural state
  logic signed [ipms_pkg::ERR_W-1:0]   err1_r, err2_r;
  logic signed [ipms_pkg::DRIVE_W-1:0] drive_last_r;
  // per-word working registers
  logic signed [ipms_pkg::ERR_W-1:0]   err_r;
  logic signed [ipms_pkg::PROD_W-1:0]  prod_r;
  logic signed [ipms_pkg::ACC_W-1:0]   acc_r;
  logic [ipms_pkg::DRIVE_W-1:0]        mag_r;
  logic                                neg_r;
  logic [ipms_pkg::NUM_W-1:0]          rem_r;
  logic [ipms_pkg::DUTY_W-1:0]         quo_r;
  logic                                special_r;
  logic [ipms_pkg::DUTY_W-1:0]         special_duty_r;
  logic [ipms_pkg::DUTY_W-1:0]         duty_r;
  logic                                dir_r;

  logic signed [ipms_pkg::COEF_W-1:0]  coef_op;
  logic signed [ipms_pkg::ERR_W-1:0]   err_op;
  logic signed [ipms_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [ipms_pkg::ERR_W-1:0]   err_nxt;
  logic signed [ipms_pkg::DRIVE_W-1:0] drive_clamped;
  logic [HI_W-1:0]                     acc_top;
  logic                                over_v;
  logic [ipms_pkg::NUM_W-1:0]          divisor_sh;
  logic [ipms_pkg::NUM_W-1:0]          num_nxt;

  assign duty_percent = duty_r;
  assign direction    = dir_r;

  // speed error, one bit wider than the inputs
  assign err_nxt = ipms_pkg::ERR_W'(target_speed) - ipms_pkg::ERR_W'(measured_speed);

  // Multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      ipms_pkg::MS_A: begin
        coef_op = cfg.coef_a;
        err_op  = err_r;
      end
      ipms_pkg::MS_B: begin
        coef_op = cfg.coef_b;
        err_op  = err1_r;
      end
      ipms_pkg::MS_C: begin
        coef_op = cfg.coef_c;
        err_op  = err2_r;
      end
      default: begin
        coef_op = cfg.coef_a;
        err_op  = err_r;
      end
    endcase
  end

  assign prod_nxt = coef_op * err_op;

  // Saturate accumulator to the signed drive width
  assign acc_top = acc_r[ipms_pkg::ACC_W-1:ipms_pkg::DRIVE_W-1];
  always_comb begin
    if (!acc_r[ipms_pkg::ACC_W-1] && (acc_top != '0))
      drive_clamped = {1'b0, {(ipms_pkg::DRIVE_W-1){1'b1}}};
    else if (acc_r[ipms_pkg::ACC_W-1] && (acc_top != '1))
      drive_clamped = {1'b1, {(ipms_pkg::DRIVE_W-1){1'b0}}};
    else
      drive_clamped = acc_r[ipms_pkg::DRIVE_W-1:0];
  end

  // Duty scaling: |u|*100, valid only when |u| <= rated voltage
  assign over_v  = mag_r > ipms_pkg::DRIVE_W'(cfg.rated_voltage);
  assign num_nxt = ipms_pkg::NUM_W'(mag_r[ipms_pkg::RATED_W-1:0])
                   * ipms_pkg::NUM_W'(ipms_pkg::DUTY_FULL);

  // Restoring divider trial divisor
  assign divisor_sh = ipms_pkg::NUM_W'(cfg.rated_voltage) << cmd.div_shift;

  // Controller state kept across words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err1_r       <= '0;
      err2_r       <= '0;
      drive_last_r <= '0;
    end else if (cmd.update) begin
      err2_r       <= err1_r;
      err1_r       <= err_r;
      drive_last_r <= drive_clamped;
    end
  end

  // Multiply-accumulate
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_r <= err_nxt;
      acc_r <= {{(ipms_pkg::ACC_W-ipms_pkg::DRIVE_W){drive_last_r[ipms_pkg::DRIVE_W-1]}},
                drive_last_r};
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + {{ACC_EXT{prod_r[ipms_pkg::PROD_W-1]}}, prod_r};
    end
    if (cmd.mul_en) prod_r <= prod_nxt;
  end

  // Magnitude, sign, duty scale and division
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      neg_r <= drive_clamped[ipms_pkg::DRIVE_W-1];
      mag_r <= drive_clamped[ipms_pkg::DRIVE_W-1] ? ipms_pkg::DRIVE_W'(-drive_clamped)
                                                  : ipms_pkg::DRIVE_W'(drive_clamped);
    end
    if (cmd.scale) begin
      rem_r          <= num_nxt;
      quo_r          <= '0;
      special_r      <= over_v || (cfg.rated_voltage == '0);
      special_duty_r <= over_v ? ipms_pkg::DUTY_W'(ipms_pkg::DUTY_FULL) : '0;
    end else if (cmd.div_step) begin
      if (rem_r >= divisor_sh) begin
        rem_r                <= rem_r - divisor_sh;
        quo_r[cmd.div_shift] <= 1'b1;
      end
    end
    // result register
    if (cmd.out_load) begin
      duty_r <= special_r ? special_duty_r : quo_r;
      dir_r  <= neg_r;
    end
  end

endmodule

// File: src/incremental_pid_motor_speed.sv
// Incremental PID motor speed controller, top level.
// One word at a time: the next word is accepted only once the previous result
// is written to the output register; that write waits while the register still
// holds an untaken result. Each word uses the shared multiplier (3 products)
// and the 7-step restoring duty divider. Reset (rst_n, synchronous) clears error
// history, stored drive and controller, and loads the coefficient defaults.
module incremental_pid_motor_speed (
  input  logic        clk,
  input  logic        rst_n,
  ipms_in_if.sink     in_ch,
  ipms_out_if.source  out_ch,
  ipms_cfg_if.sink    cfg_ch
);

  ipms_pkg::cfg_t cfg;
  ipms_pkg::cmd_t cmd;

  ipms_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ipms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ipms_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .target_speed   (in_ch.target_speed),
    .measured_speed (in_ch.measured_speed),
    .duty_percent   (out_ch.duty_percent),
    .direction      (out_ch.direction)
  );

endmodule
